/* rtl/window_speed_peak_tracker_defines.svh */
// Assertion helpers shared by the block.
`ifndef WINDOW_SPEED_PEAK_TRACKER_DEFINES_SVH
`define WINDOW_SPEED_PEAK_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WSPT_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("window speed peak tracker: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WSPT_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("window speed peak tracker: next-cycle check failed");

`endif

/* rtl/wspt_pkg.sv */
package wspt_pkg;

    // Storage sizes.
    localparam int RING_DEPTH  = 1024;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int TOP_ENTRIES = 5;
    localparam int TOP_IW      = $clog2(TOP_ENTRIES + 1);

    // Field and register widths.
    localparam int LEN_W   = 10;
    localparam int SPD_W   = 16;
    localparam int SUM_W   = 26;
    localparam int CNT_W   = 32;
    localparam int START_W = 33;
    localparam int ST_W    = CNT_W + 2;
    localparam int DIVC_W  = $clog2(SUM_W);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(100);

    // Configuration register indexes.
    localparam logic CFG_WINDOW_LEN = 1'b0;
    localparam logic CFG_TOP_ENABLE = 1'b1;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_AVG,
        ST_SCAN,
        ST_SORT,
        ST_RESP,
        ST_READ
    } state_t;

    typedef enum logic [1:0] {
        ACT_NEXT,
        ACT_SORT,
        ACT_DONE
    } scan_act_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic sum_init;
        logic div_step;
        logic avg_set;
        logic scan_step;
        logic sort_step;
        logic count_inc;
        logic out_load;
        logic read_start;
        logic read_load;
    } cmd_t;

    typedef struct packed {
        logic      div_last;
        logic      list_skip;
        scan_act_t scan_act;
        logic      sort_done;
        logic      out_free;
        logic      read_last;
    } sts_t;

endpackage

/* rtl/window_speed_peak_tracker.sv */
// Channel   Handshake             Beat contents
// in        in_valid / in_ready   mode, speed_sample
// out       out_valid / out_ready window_avg, best_avg, best_start, top_count,
//                                 entry_rank, entry_speed, entry_start, last
// cfg       cfg_we                cfg_index, cfg_data
//
// A speed sample passes from accept to result through one ring access, one sum
// update, the divider (one quotient bit per cycle) and any list scan and list
// sort compare-and-swap steps. A session reset gives one beat; a read gives one
// beat per entry (one if none), one per cycle while the output is not stalled.
// Reset clears all tracking state at once; the sample ring is not cleared.
// A stalled output holds the engine in its result step; input waits meanwhile.
`include "window_speed_peak_tracker_defines.svh"

module window_speed_peak_tracker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [wspt_pkg::LEN_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         mode,
    input  logic [wspt_pkg::SPD_W-1:0]         speed_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [wspt_pkg::SPD_W-1:0]         window_avg,
    output logic [wspt_pkg::SPD_W-1:0]         best_avg,
    output logic signed [wspt_pkg::START_W-1:0] best_start,
    output logic [2:0]                         top_count,
    output logic [2:0]                         entry_rank,
    output logic [wspt_pkg::SPD_W-1:0]         entry_speed,
    output logic [wspt_pkg::CNT_W-1:0]         entry_start,
    output logic                               last
);

    wspt_pkg::cmd_t cmd;
    wspt_pkg::sts_t sts;

    // Sequencer.
    wspt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Ring, sum, divider, top list and output register.
    wspt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .speed_sample (speed_sample),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .window_avg   (window_avg),
        .best_avg     (best_avg),
        .best_start   (best_start),
        .top_count    (top_count),
        .entry_rank   (entry_rank),
        .entry_speed  (entry_speed),
        .entry_start  (entry_start),
        .last         (last)
    );

    // A sample keeps the engine busy for at least the divider run.
    `WSPT_ASSERT_NXT(a_sample_busy, in_valid && in_ready && (mode == wspt_pkg::MODE_SAMPLE), !in_ready)
    // The best average never trails the current window average.
    `WSPT_ASSERT_IMP(a_best_covers, out_valid, window_avg <= best_avg)
    // A beat that is not the last belongs to a read with more entries behind it.
    `WSPT_ASSERT_IMP(a_rank_inside, out_valid && !last, (4'(entry_rank) + 4'd1) < 4'(top_count))

endmodule

/* rtl/wspt_ctrl.sv */
module wspt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      mode,
    input  wspt_pkg::sts_t  sts,
    output logic            in_ready,
    output wspt_pkg::cmd_t  cmd
);

    wspt_pkg::state_t state_reg;
    wspt_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wspt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands to the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            wspt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (wspt_pkg::mode_t'(mode))
                        wspt_pkg::MODE_SAMPLE:
                        begin
                            cmd.load   = 1'b1;
                            state_next = wspt_pkg::ST_SUM;
                        end
                        wspt_pkg::MODE_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = wspt_pkg::ST_RESP;
                        end
                        wspt_pkg::MODE_READ:
                        begin
                            cmd.read_start = 1'b1;
                            state_next     = wspt_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = wspt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            wspt_pkg::ST_SUM:
            begin
                cmd.sum_init = 1'b1;
                state_next   = wspt_pkg::ST_DIV;
            end
            wspt_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = wspt_pkg::ST_AVG;
                end
            end
            wspt_pkg::ST_AVG:
            begin
                cmd.avg_set = 1'b1;
                if (sts.list_skip)
                begin
                    cmd.count_inc = 1'b1;
                    state_next    = wspt_pkg::ST_RESP;
                end
                else
                begin
                    state_next = wspt_pkg::ST_SCAN;
                end
            end
            wspt_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                case (sts.scan_act)
                    wspt_pkg::ACT_SORT:
                    begin
                        state_next = wspt_pkg::ST_SORT;
                    end
                    wspt_pkg::ACT_DONE:
                    begin
                        cmd.count_inc = 1'b1;
                        state_next    = wspt_pkg::ST_RESP;
                    end
                    default:
                    begin
                        state_next = wspt_pkg::ST_SCAN;
                    end
                endcase
            end
            wspt_pkg::ST_SORT:
            begin
                if (sts.sort_done)
                begin
                    cmd.count_inc = 1'b1;
                    state_next    = wspt_pkg::ST_RESP;
                end
                else
                begin
                    cmd.sort_step = 1'b1;
                end
            end
            wspt_pkg::ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = wspt_pkg::ST_IDLE;
                end
            end
            wspt_pkg::ST_READ:
            begin
                if (sts.out_free)
                begin
                    cmd.read_load = 1'b1;
                    if (sts.read_last)
                    begin
                        state_next = wspt_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = wspt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/wspt_dp.sv */
module wspt_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [wspt_pkg::LEN_W-1:0]    cfg_data,
    input  logic [wspt_pkg::SPD_W-1:0]    speed_sample,
    input  wspt_pkg::cmd_t                cmd,
    output wspt_pkg::sts_t                sts,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [wspt_pkg::SPD_W-1:0]    window_avg,
    output logic [wspt_pkg::SPD_W-1:0]    best_avg,
    output logic signed [wspt_pkg::START_W-1:0] best_start,
    output logic [2:0]                    top_count,
    output logic [2:0]                    entry_rank,
    output logic [wspt_pkg::SPD_W-1:0]    entry_speed,
    output logic [wspt_pkg::CNT_W-1:0]    entry_start,
    output logic                          last
);

    localparam int LEN_W   = wspt_pkg::LEN_W;
    localparam int SPD_W   = wspt_pkg::SPD_W;
    localparam int SUM_W   = wspt_pkg::SUM_W;
    localparam int CNT_W   = wspt_pkg::CNT_W;
    localparam int ST_W    = wspt_pkg::ST_W;
    localparam int TOP_IW  = wspt_pkg::TOP_IW;
    localparam int TOP_N   = wspt_pkg::TOP_ENTRIES;

    // Configuration registers.
    logic [LEN_W-1:0] win_len_reg;
    logic             top_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= wspt_pkg::LEN_RESET;
            top_en_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == wspt_pkg::CFG_WINDOW_LEN)
            begin
                win_len_reg <= cfg_data;
            end
            else
            begin
                top_en_reg <= cfg_data[0];
            end
        end
    end

    // Effective window length: zero acts as one, clipped below the ring depth.
    logic [LEN_W-1:0] eff_len;

    always_comb
    begin
        eff_len = win_len_reg;
        if (win_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(win_len_reg) >= wspt_pkg::RING_DEPTH)
        begin
            eff_len = LEN_W'(wspt_pkg::RING_DEPTH - 1);
        end
    end

    // Session state.
    logic [SUM_W-1:0]               sum_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [SPD_W-1:0]               avg_reg;
    logic [SPD_W-1:0]               best_reg;
    logic signed [wspt_pkg::START_W-1:0] best_start_reg;
    logic [SPD_W-1:0]               top_speed_reg [TOP_N];
    logic [CNT_W-1:0]               top_start_reg [TOP_N];
    logic [TOP_IW-1:0]              held_reg;

    // Ring of past samples, one write and one registered read per cycle in which a sample is loaded.
    logic [SPD_W-1:0]       ring_mem [wspt_pkg::RING_DEPTH];
    logic [SPD_W-1:0]       rd_data_reg;
    logic [SPD_W-1:0]       spd_reg;
    logic                   has_old_reg;
    logic [CNT_W-1:0]       old_pos;
    logic                   has_old;

    assign old_pos = count_reg - CNT_W'(eff_len);
    assign has_old = count_reg >= CNT_W'(eff_len);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ring_mem[count_reg[wspt_pkg::RING_AW-1:0]] <= speed_sample;
            rd_data_reg <= ring_mem[old_pos[wspt_pkg::RING_AW-1:0]];
            spd_reg     <= speed_sample;
            has_old_reg <= has_old;
        end
    end

    // New window sum: add the new sample, drop the one leaving the window.
    logic [SUM_W-1:0] sum_new;

    assign sum_new = sum_reg + SUM_W'(spd_reg)
                     - (has_old_reg ? SUM_W'(rd_data_reg) : SUM_W'(0));

    // Restoring divider, one quotient bit per cycle; the quotient shifts
    // into the dividend register.
    logic [SUM_W-1:0]            dvd_reg;
    logic [LEN_W-1:0]            rem_reg;
    logic [wspt_pkg::DIVC_W-1:0] divc_reg;
    logic [LEN_W:0]              trial;
    logic [LEN_W:0]              diff;
    logic                        q_bit;

    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, eff_len};
    assign q_bit = trial >= {1'b0, eff_len};

    always_ff @(posedge clk)
    begin
        if (cmd.sum_init)
        begin
            dvd_reg  <= sum_new;
            rem_reg  <= '0;
            divc_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg  <= {dvd_reg[SUM_W-2:0], q_bit};
            rem_reg  <= q_bit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            divc_reg <= divc_reg + 1'b1;
        end
    end

    // Saturated average once the divider is through.
    logic [SPD_W-1:0] avg_new;

    assign avg_new = (|dvd_reg[SUM_W-1:SPD_W]) ? '1 : dvd_reg[SPD_W-1:0];

    // Window start index and overlap test against the scanned entry.
    logic signed [ST_W-1:0] st;
    logic signed [ST_W-1:0] len_s;
    logic signed [ST_W-1:0] other;
    logic                   overlap;
    logic [TOP_IW-1:0]      k_reg;

    assign len_s   = $signed({{(ST_W - LEN_W){1'b0}}, eff_len});
    assign st      = $signed({2'b00, count_reg}) - len_s + ST_W'(1);
    assign other   = $signed({2'b00, top_start_reg[k_reg]});
    assign overlap = (st < other + len_s) && (other < st + len_s);

    // Scan decision for entry k.
    wspt_pkg::scan_act_t scan_act;
    logic [TOP_IW-1:0]   wr_ix;
    logic                grow;

    always_comb
    begin
        scan_act = wspt_pkg::ACT_NEXT;
        wr_ix    = k_reg;
        grow     = 1'b0;
        if (k_reg == held_reg)
        begin
            if (32'(held_reg) < TOP_N)
            begin
                scan_act = wspt_pkg::ACT_SORT;
                wr_ix    = held_reg;
                grow     = 1'b1;
            end
            else if (avg_reg > top_speed_reg[TOP_N-1])
            begin
                scan_act = wspt_pkg::ACT_SORT;
                wr_ix    = TOP_IW'(TOP_N - 1);
            end
            else
            begin
                scan_act = wspt_pkg::ACT_DONE;
            end
        end
        else if (overlap)
        begin
            scan_act = (avg_reg > top_speed_reg[k_reg]) ? wspt_pkg::ACT_SORT
                                                        : wspt_pkg::ACT_DONE;
        end
    end

    // Exchange sort over the held entries, one compare and swap per cycle.
    logic [TOP_IW-1:0] a_reg;
    logic [TOP_IW-1:0] b_reg;
    logic              sort_done;
    logic              swap;

    assign sort_done = ({1'b0, a_reg} + 1'b1) >= {1'b0, held_reg};
    assign swap      = top_speed_reg[a_reg] < top_speed_reg[b_reg];

    // Read-out index.
    logic [TOP_IW-1:0] rk_reg;
    logic              read_last;

    assign read_last = (held_reg == '0) || (({1'b0, rk_reg} + 1'b1) == {1'b0, held_reg});

    // Tracking state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            count_reg      <= '0;
            avg_reg        <= '0;
            best_reg       <= '0;
            best_start_reg <= '1;
            held_reg       <= '0;
            k_reg          <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            rk_reg         <= '0;
            for (int i = 0; i < TOP_N; i++)
            begin
                top_speed_reg[i] <= '0;
                top_start_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                sum_reg        <= '0;
                count_reg      <= '0;
                avg_reg        <= '0;
                best_reg       <= '0;
                best_start_reg <= '1;
                held_reg       <= '0;
                for (int i = 0; i < TOP_N; i++)
                begin
                    top_speed_reg[i] <= '0;
                    top_start_reg[i] <= '0;
                end
            end
            if (cmd.sum_init)
            begin
                sum_reg <= sum_new;
            end
            if (cmd.avg_set)
            begin
                avg_reg <= avg_new;
                k_reg   <= '0;
                if (best_reg < avg_new)
                begin
                    best_reg       <= avg_new;
                    best_start_reg <= st[wspt_pkg::START_W-1:0];
                end
            end
            if (cmd.scan_step)
            begin
                if (scan_act == wspt_pkg::ACT_SORT)
                begin
                    top_speed_reg[wr_ix] <= avg_reg;
                    top_start_reg[wr_ix] <= st[CNT_W-1:0];
                    a_reg <= '0;
                    b_reg <= TOP_IW'(1);
                    if (grow)
                    begin
                        held_reg <= held_reg + 1'b1;
                    end
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            if (cmd.sort_step)
            begin
                if (swap)
                begin
                    top_speed_reg[a_reg] <= top_speed_reg[b_reg];
                    top_speed_reg[b_reg] <= top_speed_reg[a_reg];
                    top_start_reg[a_reg] <= top_start_reg[b_reg];
                    top_start_reg[b_reg] <= top_start_reg[a_reg];
                end
                if (({1'b0, b_reg} + 1'b1) < {1'b0, held_reg})
                begin
                    b_reg <= b_reg + 1'b1;
                end
                else
                begin
                    a_reg <= a_reg + 1'b1;
                    b_reg <= a_reg + TOP_IW'(2);
                end
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.read_start)
            begin
                rk_reg <= '0;
            end
            else if (cmd.read_load)
            begin
                rk_reg <= rk_reg + 1'b1;
            end
        end
    end

    // Output register; it takes a new beat once the old one is gone.
    logic out_valid_reg;
    logic out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load || cmd.read_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load || cmd.read_load)
        begin
            window_avg  <= avg_reg;
            best_avg    <= best_reg;
            best_start  <= best_start_reg;
            top_count   <= 3'(held_reg);
            entry_rank  <= '0;
            entry_speed <= '0;
            entry_start <= '0;
            last        <= 1'b1;
            if (cmd.read_load && (held_reg != '0))
            begin
                entry_rank  <= 3'(rk_reg);
                entry_speed <= top_speed_reg[rk_reg];
                entry_start <= top_start_reg[rk_reg];
                last        <= read_last;
            end
        end
    end

    assign out_valid = out_valid_reg;

    // Status to the controller.
    always_comb
    begin
        sts.div_last  = divc_reg == wspt_pkg::DIVC_W'(SUM_W - 1);
        sts.list_skip = !top_en_reg || st[ST_W-1] || (avg_new == '0);
        sts.scan_act  = scan_act;
        sts.sort_done = sort_done;
        sts.out_free  = out_free;
        sts.read_last = read_last;
    end

endmodule

/* sim/tb_window_speed_peak_tracker.sv */
`timescale 1ns / 100ps

module tb_window_speed_peak_tracker;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    // One output beat as seen on the port.
    typedef struct packed {
        logic [15:0]        window_avg;
        logic [15:0]        best_avg;
        logic signed [32:0] best_start;
        logic [2:0]         top_count;
        logic [2:0]         entry_rank;
        logic [15:0]        entry_speed;
        logic [31:0]        entry_start;
        logic               last;
    } beat_t;

    // Directed stimulus row: typed rows carry their own expected beat.
    typedef struct {
        wspt_pkg::mode_t op;
        logic [15:0]     speed;
        bit              typed;
        beat_t           want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [9:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [15:0] speed_sample;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] window_avg;
    logic [15:0] best_avg;
    logic signed [32:0] best_start;
    logic [2:0]  top_count;
    logic [2:0]  entry_rank;
    logic [15:0] entry_speed;
    logic [31:0] entry_start;
    logic        last;

    window_speed_peak_tracker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .speed_sample (speed_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_avg   (window_avg),
        .best_avg     (best_avg),
        .best_start   (best_start),
        .top_count    (top_count),
        .entry_rank   (entry_rank),
        .entry_speed  (entry_speed),
        .entry_start  (entry_start),
        .last         (last)
    );

    // Tracker state as the testbench models it.
    logic [15:0] ring_mem [wspt_pkg::RING_DEPTH];
    logic [25:0] run_sum;
    logic [31:0] sample_idx;
    logic [15:0] cur_avg;
    logic [15:0] peak_avg;
    logic signed [32:0] peak_start;
    logic [15:0] rank_speed [wspt_pkg::TOP_ENTRIES];
    logic [31:0] rank_start [wspt_pkg::TOP_ENTRIES];
    int          ranked_held;
    logic [9:0]  len_reg;
    logic        rank_on;

    beat_t pending_beats[$];
    int    mismatch_count;
    int    cycle_count;
    int    burst_left;
    row_t  rows[$];

    // A typed row replaces the predicted beat of its input with this one.
    bit    typed_next;
    beat_t typed_want;

    // Clock and timeout.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: the stall pattern rotates through four styles.
    always @(posedge clk)
    begin
        case ((cycle_count / 64) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ((cycle_count % 5) != 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Compare each accepted output beat with the oldest expectation.
    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{window_avg, best_avg, best_start, top_count, entry_rank,
                    entry_speed, entry_start, last};
            if (pending_beats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: %p", got);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    function automatic longint span();
        if (len_reg == 0)
            return 1;
        if (len_reg >= wspt_pkg::RING_DEPTH)
            return wspt_pkg::RING_DEPTH - 1;
        return len_reg;
    endfunction

    function automatic beat_t status_beat(int rank, logic [15:0] spd, logic [31:0] st,
                                          bit fin);
        return '{cur_avg, peak_avg, peak_start, 3'(ranked_held), 3'(rank), spd, st, fin};
    endfunction

    function automatic void clear_tracking();
        run_sum = '0;
        sample_idx = '0;
        cur_avg = '0;
        peak_avg = '0;
        peak_start = -33'sd1;
        ranked_held = 0;
        for (int k = 0; k < wspt_pkg::TOP_ENTRIES; k++)
        begin
            rank_speed[k] = '0;
            rank_start[k] = '0;
        end
    endfunction

    // Keep the list ordered fastest first.
    function automatic void order_ranking();
        logic [15:0] ts;
        logic [31:0] tt;
        for (int a = 0; a + 1 < ranked_held; a++)
            for (int b = a + 1; b < ranked_held; b++)
                if (rank_speed[a] < rank_speed[b])
                begin
                    ts = rank_speed[a]; rank_speed[a] = rank_speed[b]; rank_speed[b] = ts;
                    tt = rank_start[a]; rank_start[a] = rank_start[b]; rank_start[b] = tt;
                end
    endfunction

    // Merge the current window into the ranked list of non-overlapping windows.
    function automatic void merge_window(longint st, logic [15:0] spd, longint n);
        longint other;
        if (st < 0 || spd == 0)
            return;
        for (int k = 0; k < ranked_held; k++)
        begin
            other = rank_start[k];
            if (st < other + n && other < st + n)
            begin
                if (spd > rank_speed[k])
                begin
                    rank_speed[k] = spd;
                    rank_start[k] = st[31:0];
                    order_ranking();
                end
                return;
            end
        end
        if (ranked_held < wspt_pkg::TOP_ENTRIES)
        begin
            rank_speed[ranked_held] = spd;
            rank_start[ranked_held] = st[31:0];
            ranked_held++;
            order_ranking();
            return;
        end
        if (spd <= rank_speed[wspt_pkg::TOP_ENTRIES-1])
            return;
        rank_speed[wspt_pkg::TOP_ENTRIES-1] = spd;
        rank_start[wspt_pkg::TOP_ENTRIES-1] = st[31:0];
        order_ranking();
    endfunction

    // Advance the tracker by one accepted beat and queue the beats it gives.
    function automatic void track_step(wspt_pkg::mode_t op, logic [15:0] spd);
        longint n;
        longint st;
        logic [25:0] q;
        case (op)
            wspt_pkg::MODE_SAMPLE:
            begin
                n = span();
                st = longint'(sample_idx) - n + 1;
                ring_mem[sample_idx % wspt_pkg::RING_DEPTH] = spd;
                run_sum = run_sum + spd;
                if (longint'(sample_idx) >= n)
                    run_sum = run_sum
                              - ring_mem[(longint'(sample_idx) - n) % wspt_pkg::RING_DEPTH];
                q = run_sum / 26'(n);
                cur_avg = (q > 26'hFFFF) ? 16'hFFFF : q[15:0];
                if (rank_on)
                    merge_window(st, cur_avg, n);
                if (peak_avg < cur_avg)
                begin
                    peak_avg = cur_avg;
                    peak_start = st[32:0];
                end
                sample_idx++;
                pending_beats.push_back(status_beat(0, '0, '0, 1'b1));
            end
            wspt_pkg::MODE_CLEAR:
            begin
                clear_tracking();
                pending_beats.push_back(status_beat(0, '0, '0, 1'b1));
            end
            wspt_pkg::MODE_READ:
            begin
                if (ranked_held == 0)
                    pending_beats.push_back(status_beat(0, '0, '0, 1'b1));
                for (int k = 0; k < ranked_held; k++)
                    pending_beats.push_back(status_beat(k, rank_speed[k], rank_start[k],
                                                        k + 1 == ranked_held));
            end
            default:
            begin
            end
        endcase
    endfunction

    // Present one beat and hold it until accepted, then maybe leave a gap.
    task automatic send_beat(wspt_pkg::mode_t op, logic [15:0] spd);
        int gap;
        in_valid <= 1'b1;
        mode <= op;
        speed_sample <= spd;
        do
            @(posedge clk);
        while (!in_ready);
        track_step(op, spd);
        if (typed_next)
        begin
            void'(pending_beats.pop_back());
            pending_beats.push_back(typed_want);
            typed_next = 1'b0;
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold the input off until every expected beat has come and the engine is quiet.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [9:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == wspt_pkg::CFG_WINDOW_LEN)
            len_reg = value;
        else
            rank_on = value[0];
    endtask

    // Set a new window length; a longer window starts a fresh session so that
    // the ring is never read where this session has not written it.
    task automatic set_window(logic [9:0] value, bit keep_session);
        longint prev;
        prev = span();
        drain();
        write_reg(wspt_pkg::CFG_WINDOW_LEN, value);
        if (!keep_session || span() > prev)
            send_beat(wspt_pkg::MODE_CLEAR, 16'($urandom()));
    endtask

    function automatic void add_row(wspt_pkg::mode_t op, logic [15:0] spd, bit typed);
        row_t r;
        r.op = op;
        r.speed = spd;
        r.typed = typed;
        r.want = '{16'd0, 16'd0, -33'sd1, 3'd0, 3'd0, 16'd0, 32'd0, 1'b1};
        rows.push_back(r);
    endfunction

    task automatic random_phase(int count);
        int pick;
        logic [15:0] level;
        level = 16'($urandom());
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_beat(wspt_pkg::MODE_READ, 16'($urandom()));
            else if (pick < 11)
                send_beat(wspt_pkg::MODE_CLEAR, 16'($urandom()));
            else if (pick < 14)
                send_beat(wspt_pkg::MODE_NONE, 16'($urandom()));
            else
            begin
                // Speeds drift around a level, with occasional extremes.
                if ($urandom_range(0, 9) == 0)
                    level = 16'($urandom());
                case ($urandom_range(0, 9))
                    0: send_beat(wspt_pkg::MODE_SAMPLE, 16'hFFFF);
                    1: send_beat(wspt_pkg::MODE_SAMPLE, 16'h0000);
                    2: send_beat(wspt_pkg::MODE_SAMPLE, 16'($urandom()));
                    default: send_beat(wspt_pkg::MODE_SAMPLE,
                                       level + 16'($urandom_range(0, 2000)));
                endcase
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        mismatch_count = 0;
        burst_left = 4;
        typed_next = 1'b0;
        typed_want = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = wspt_pkg::CFG_WINDOW_LEN;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = wspt_pkg::MODE_NONE;
        speed_sample = '0;
        len_reg = wspt_pkg::LEN_RESET;
        rank_on = 1'b1;
        for (int k = 0; k < wspt_pkg::RING_DEPTH; k++)
            ring_mem[k] = '0;
        clear_tracking();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings: empty read, clear, ignored mode, extremes.
        add_row(wspt_pkg::MODE_READ, 16'h0000, 1'b1);
        add_row(wspt_pkg::MODE_CLEAR, 16'hFFFF, 1'b1);
        add_row(wspt_pkg::MODE_NONE, 16'hFFFF, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'hFFFF, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'h0000, 1'b0);
        add_row(wspt_pkg::MODE_READ, 16'h1234, 1'b0);
        add_row(wspt_pkg::MODE_CLEAR, 16'h0000, 1'b1);
        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                typed_want = rows[i].want;
                typed_next = 1'b1;
            end
            send_beat(rows[i].op, rows[i].speed);
        end

        // Directed part with a short window: overlap, append, full list, replace.
        set_window(10'd2, 1'b0);
        rows.delete();
        add_row(wspt_pkg::MODE_SAMPLE, 16'd100, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd300, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd500, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd50, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd50, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd900, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd900, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd10, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd10, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd700, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd700, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd0, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'd0, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'hFFFF, 1'b0);
        add_row(wspt_pkg::MODE_SAMPLE, 16'hFFFF, 1'b0);
        add_row(wspt_pkg::MODE_READ, 16'd0, 1'b0);
        foreach (rows[i])
            send_beat(rows[i].op, rows[i].speed);

        // Random phases over a range of settings, the extremes included.
        set_window(10'd0, 1'b0);
        random_phase(30);
        drain();
        write_reg(wspt_pkg::CFG_TOP_ENABLE, 10'd0);
        random_phase(25);
        drain();
        write_reg(wspt_pkg::CFG_TOP_ENABLE, 10'd1);
        set_window(10'd1023, 1'b0);
        random_phase(25);
        set_window(10'd100, 1'b0);
        for (int i = 0; i < 110; i++)
            send_beat(wspt_pkg::MODE_SAMPLE, 16'hFFFF - 16'($urandom_range(0, 3)));
        // Shrink with the session kept: the stale sum saturates the average.
        set_window(10'd1, 1'b1);
        random_phase(10);
        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_reg(wspt_pkg::CFG_TOP_ENABLE, 10'($urandom_range(0, 3) != 0));
            set_window(10'($urandom_range(1, 12)), ($urandom_range(0, 1) == 1));
            random_phase($urandom_range(20, 30));
        end
        send_beat(wspt_pkg::MODE_READ, 16'd0);

        // Wind down and report.
        drain();
        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/wspt_pkg.sv
rtl/wspt_ctrl.sv
rtl/wspt_dp.sv
rtl/window_speed_peak_tracker.sv
sim/tb_window_speed_peak_tracker.sv
